FILE: hdl/fbmf_pkg.sv
// Package for the FFT bin mask filter: shared types, register indexes,
// fixed-point rounding helpers and the twiddle series evaluation.
// No dependencies.
package fbmf_pkg;

  localparam int IDX_W = 6;
  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;
  localparam logic [63:0] HALF_Q30 = 64'd536870912;

  localparam logic [1:0] REG_BIN_LOW  = 2'd0;
  localparam logic [1:0] REG_BIN_HIGH = 2'd1;
  localparam logic [1:0] REG_GAIN     = 2'd2;

  typedef enum logic [4:0] {
    ST_FILL   = 5'b00001,
    ST_FWD    = 5'b00010,
    ST_FDRAIN = 5'b00100,
    ST_INV    = 5'b01000,
    ST_IWAIT  = 5'b10000
  } state_t;

  typedef struct packed {
    logic             issue;
    logic             inv;
    logic [IDX_W-1:0] inner;
    logic [IDX_W-1:0] outer;
    logic [IDX_W-1:0] twi;
    logic             first;
    logic             last;
    logic             frame_end;
    logic             wr_sample;
    logic [IDX_W-1:0] wr_addr;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] c;
    logic signed [31:0] s;
  } trig_t;

  function automatic logic signed [63:0] rnd64(input logic signed [63:0] v,
                                               input int sh);
    logic signed [63:0] bias;
    bias = 64'sd1 <<< (sh - 1);
    return (v + bias) >>> sh;
  endfunction

  function automatic logic [63:0] div_sin(input logic [63:0] v, input int k);
    case (k)
      1: return (v + 64'd3) / 64'd6;
      2: return (v + 64'd10) / 64'd20;
      3: return (v + 64'd21) / 64'd42;
      4: return (v + 64'd36) / 64'd72;
      5: return (v + 64'd55) / 64'd110;
      6: return (v + 64'd78) / 64'd156;
      7: return (v + 64'd105) / 64'd210;
      8: return (v + 64'd136) / 64'd272;
      9: return (v + 64'd171) / 64'd342;
      default: return v;
    endcase
  endfunction

  function automatic logic [63:0] div_cos(input logic [63:0] v, input int k);
    case (k)
      1: return (v + 64'd1) / 64'd2;
      2: return (v + 64'd6) / 64'd12;
      3: return (v + 64'd15) / 64'd30;
      4: return (v + 64'd28) / 64'd56;
      5: return (v + 64'd45) / 64'd90;
      6: return (v + 64'd66) / 64'd132;
      7: return (v + 64'd91) / 64'd182;
      8: return (v + 64'd120) / 64'd240;
      9: return (v + 64'd153) / 64'd306;
      default: return v;
    endcase
  endfunction

  // Taylor series of cos and sin in Q2.30 for an angle in the first quadrant.
  function automatic trig_t trig_series(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] ts;
    logic [63:0] tc;
    logic signed [63:0] s;
    logic signed [63:0] c;
    trig_t r;
    x2 = (x * x + HALF_Q30) >> 30;
    ts = x;
    tc = ONE_Q30;
    s = signed'(x);
    c = signed'(ONE_Q30);
    for (int k = 1; k <= 9; k++) begin
      ts = div_sin((ts * x2 + HALF_Q30) >> 30, k);
      tc = div_cos((tc * x2 + HALF_Q30) >> 30, k);
      if ((k % 2) == 1) begin
        s = s - signed'(ts);
        c = c - signed'(tc);
      end else begin
        s = s + signed'(ts);
        c = c + signed'(tc);
      end
    end
    r.c = c[31:0];
    r.s = s[31:0];
    return r;
  endfunction

endpackage

FILE: hdl/fbmf_ctrl.sv
// Controller state machine of the FFT bin mask filter: frame fill, forward
// and inverse transform sequencing and output pacing.
// Depends on fbmf_pkg.
module fbmf_ctrl #(
  parameter int FRAME_LEN = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          busy,
  output fbmf_pkg::cmd_t cmd
);

  localparam int IW = $clog2(FRAME_LEN);
  localparam logic [IW-1:0] LAST_IDX = IW'(FRAME_LEN - 1);
  localparam logic [IW:0] LEN_EXT = (IW + 1)'(FRAME_LEN);

  fbmf_pkg::state_t state, state_next;
  logic [IW-1:0] inner, inner_next;
  logic [IW-1:0] outer, outer_next;
  logic [IW-1:0] twi, twi_next;
  logic [IW:0] twi_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fbmf_pkg::ST_FILL;
      inner <= '0;
      outer <= '0;
      twi <= '0;
    end else begin
      state <= state_next;
      inner <= inner_next;
      outer <= outer_next;
      twi <= twi_next;
    end
  end

  always_comb begin
    twi_sum = {1'b0, twi} + {1'b0, outer};
    if (twi_sum >= LEN_EXT) begin
      twi_sum = twi_sum - LEN_EXT;
    end
  end

  always_comb begin
    state_next = state;
    inner_next = inner;
    outer_next = outer;
    twi_next = twi;
    in_ready = 1'b0;
    cmd = '0;
    cmd.inner = fbmf_pkg::IDX_W'(inner);
    cmd.outer = fbmf_pkg::IDX_W'(outer);
    cmd.twi = fbmf_pkg::IDX_W'(twi);
    cmd.wr_addr = fbmf_pkg::IDX_W'(inner);
    cmd.first = (inner == '0);
    cmd.last = (inner == LAST_IDX);
    cmd.frame_end = (outer == LAST_IDX);
    case (state)
      fbmf_pkg::ST_FILL: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.wr_sample = 1'b1;
          if (inner == LAST_IDX) begin
            inner_next = '0;
            outer_next = '0;
            twi_next = '0;
            state_next = fbmf_pkg::ST_FWD;
          end else begin
            inner_next = inner + 1'b1;
          end
        end
      end
      fbmf_pkg::ST_FWD, fbmf_pkg::ST_INV: begin
        cmd.issue = 1'b1;
        cmd.inv = (state == fbmf_pkg::ST_INV);
        if (inner == LAST_IDX) begin
          inner_next = '0;
          twi_next = '0;
          if (state == fbmf_pkg::ST_INV) begin
            state_next = fbmf_pkg::ST_IWAIT;
          end else if (outer == LAST_IDX) begin
            outer_next = '0;
            state_next = fbmf_pkg::ST_FDRAIN;
          end else begin
            outer_next = outer + 1'b1;
          end
        end else begin
          inner_next = inner + 1'b1;
          twi_next = twi_sum[IW-1:0];
        end
      end
      fbmf_pkg::ST_FDRAIN: begin
        if (!busy) begin
          state_next = fbmf_pkg::ST_INV;
        end
      end
      fbmf_pkg::ST_IWAIT: begin
        if (!busy) begin
          if (outer == LAST_IDX) begin
            outer_next = '0;
            state_next = fbmf_pkg::ST_FILL;
          end else begin
            outer_next = outer + 1'b1;
            state_next = fbmf_pkg::ST_INV;
          end
        end
      end
      default: begin
        state_next = fbmf_pkg::ST_FILL;
      end
    endcase
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst) in_ready |-> !busy)
    else $error("Input taken while the datapath is busy.");
  assert property (@(posedge clk) disable iff (rst)
    (state == fbmf_pkg::ST_FDRAIN) |-> (inner == '0 && outer == '0))
    else $error("Counters not cleared at end of forward pass.");
  assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("Controller state is not one-hot.");
`endif

endmodule

FILE: hdl/fbmf_datapath.sv
// Datapath of the FFT bin mask filter: frame and spectrum memories, twiddle
// table, complex multiply-accumulate pipeline, gain stage and output register.
// Depends on fbmf_pkg.
module fbmf_datapath #(
  parameter int FRAME_LEN = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  fbmf_pkg::cmd_t     cmd,
  input  logic signed [15:0] sample_i,
  input  logic signed [15:0] sample_q,
  input  logic [5:0]         bin_low,
  input  logic [5:0]         bin_high,
  input  logic signed [31:0] gain,
  output logic               busy,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_i,
  output logic signed [15:0] out_q,
  output logic               frame_last
);

  localparam int IW = $clog2(FRAME_LEN);

  logic signed [31:0] tw_cos [FRAME_LEN];
  logic signed [31:0] tw_sin [FRAME_LEN];

  for (genvar m = 0; m < FRAME_LEN; m++) begin : g_tw
    localparam int Q = (4 * m) / FRAME_LEN;
    localparam int R = (4 * m) % FRAME_LEN;
    localparam logic [63:0] X =
      (fbmf_pkg::PI_Q30 * 64'(R) + 64'(FRAME_LEN)) / (64'(2 * FRAME_LEN));
    localparam fbmf_pkg::trig_t T = fbmf_pkg::trig_series(X);
    if (Q == 0) begin : g_q0
      assign tw_cos[m] = T.c;
      assign tw_sin[m] = T.s;
    end else if (Q == 1) begin : g_q1
      assign tw_cos[m] = -T.s;
      assign tw_sin[m] = T.c;
    end else if (Q == 2) begin : g_q2
      assign tw_cos[m] = -T.c;
      assign tw_sin[m] = -T.s;
    end else begin : g_q3
      assign tw_cos[m] = T.s;
      assign tw_sin[m] = -T.c;
    end
  end

  logic [31:0] frame_mem [FRAME_LEN];
  logic [63:0] spec_mem [FRAME_LEN];

  logic spec_we;
  logic [63:0] spec_wdata;
  logic [IW-1:0] outer3;

  logic [31:0] fr_rd;
  logic [63:0] sp_rd;
  logic signed [31:0] tw_c1, tw_s1;
  logic v1, inv1, first1, last1, end1, band1;
  logic [IW-1:0] outer1;
  logic [5:0] band_idx;

  logic signed [31:0] a, b;
  logic signed [63:0] p0, p1, p2, p3;
  logic v2, inv2, first2, last2, end2, band2;
  logic [IW-1:0] outer2;

  logic signed [63:0] term_r, term_i, acc_r, acc_i;
  logic v3, inv3, end3, band3;

  logic signed [63:0] fwd_r, fwd_i, inv_r, inv_i;
  logic signed [36:0] y_r, y_i;
  logic v4, end4;

  logic signed [68:0] prod_r, prod_i;
  logic v5, end5;

  function automatic logic signed [15:0] sat_out(input logic signed [68:0] p);
    logic signed [68:0] v;
    v = (p + (69'sd1 <<< 26)) >>> 27;
    if (v > 69'sd32767) begin
      return 16'sh7fff;
    end else if (v < -69'sd32768) begin
      return 16'sh8000;
    end else begin
      return v[15:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.wr_sample) begin
      frame_mem[cmd.wr_addr[IW-1:0]] <= {sample_q, sample_i};
    end
    if (spec_we) begin
      spec_mem[outer3] <= spec_wdata;
    end
    fr_rd <= frame_mem[cmd.inner[IW-1:0]];
    sp_rd <= spec_mem[cmd.inner[IW-1:0]];
  end

  assign band_idx = cmd.inv ? 6'(cmd.inner[IW-1:0]) : 6'(cmd.outer[IW-1:0]);

  always_ff @(posedge clk) begin
    tw_c1 <= tw_cos[cmd.twi[IW-1:0]];
    tw_s1 <= tw_sin[cmd.twi[IW-1:0]];
    inv1 <= cmd.inv;
    first1 <= cmd.first;
    last1 <= cmd.last;
    end1 <= cmd.frame_end;
    outer1 <= cmd.outer[IW-1:0];
    band1 <= (band_idx >= bin_low) && (band_idx <= bin_high);
  end

  always_comb begin
    if (inv1) begin
      a = signed'(sp_rd[31:0]);
      b = signed'(sp_rd[63:32]);
    end else begin
      a = 32'(signed'(fr_rd[15:0]));
      b = 32'(signed'(fr_rd[31:16]));
    end
  end

  always_ff @(posedge clk) begin
    p0 <= a * tw_c1;
    p1 <= b * tw_s1;
    p2 <= b * tw_c1;
    p3 <= a * tw_s1;
    inv2 <= inv1;
    first2 <= first1;
    last2 <= last1;
    end2 <= end1;
    outer2 <= outer1;
    band2 <= band1;
  end

  always_comb begin
    if (inv2) begin
      term_r = band2 ? fbmf_pkg::rnd64(p0 - p1, 8) : '0;
      term_i = band2 ? fbmf_pkg::rnd64(p3 + p2, 8) : '0;
    end else begin
      term_r = p0 + p1;
      term_i = p2 - p3;
    end
  end

  always_ff @(posedge clk) begin
    if (v2) begin
      acc_r <= first2 ? term_r : acc_r + term_r;
      acc_i <= first2 ? term_i : acc_i + term_i;
    end
    inv3 <= inv2;
    end3 <= end2;
    outer3 <= outer2;
    band3 <= band2;
  end

  assign fwd_r = fbmf_pkg::rnd64(acc_r, 22);
  assign fwd_i = fbmf_pkg::rnd64(acc_i, 22);
  assign inv_r = fbmf_pkg::rnd64(acc_r, 27);
  assign inv_i = fbmf_pkg::rnd64(acc_i, 27);
  assign spec_we = v3 && !inv3;
  assign spec_wdata = band3 ? {fwd_i[31:0], fwd_r[31:0]} : 64'd0;

  always_ff @(posedge clk) begin
    if (v3) begin
      y_r <= inv_r[36:0];
      y_i <= inv_i[36:0];
      end4 <= end3;
    end
    if (v4) begin
      prod_r <= y_r * gain;
      prod_i <= y_i * gain;
      end5 <= end4;
    end
    if (v5) begin
      out_i <= sat_out(prod_r);
      out_q <= sat_out(prod_i);
      frame_last <= end5;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
      v3 <= v2 && last2;
      v4 <= v3 && inv3;
      v5 <= v4;
      if (v5) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign busy = v1 | v2 | v3 | v4 | v5 | out_valid;

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst) cmd.issue |-> !out_valid)
    else $error("Transform step issued while an output transaction is pending.");
  assert property (@(posedge clk) disable iff (rst)
    spec_we |-> !(cmd.issue && cmd.inv))
    else $error("Spectrum written during the inverse pass.");
  assert property (@(posedge clk) disable iff (rst) v5 |-> !out_valid)
    else $error("Output register overwritten before it was taken.");
`endif

endmodule

FILE: hdl/fft_bin_mask_filter_top.sv
// Top level of the FFT bin mask filter: APB register file, controller and
// datapath. Depends on fbmf_pkg, fbmf_ctrl and fbmf_datapath.
//
// Complex samples are collected into frames of FRAME_LEN; a full frame runs a
// direct forward DFT, masks bins outside bin_low..bin_high, runs an inverse
// DFT and emits FRAME_LEN scaled and saturated samples, frame_last on the
// final one. One complex multiply-accumulate unit does all the work, so a
// frame is processed in full after its last input before input is taken
// again; stalls on the output side lengthen the processing of a frame.
// Input is not accepted while a frame is being processed. Registers: bin_low
// at 0x0, bin_high at 0x4, gain (signed, units of 2^-27) at 0x8; write them
// only when idle.
module fft_bin_mask_filter_top #(
  parameter int FRAME_LEN = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] sample_i,
  input  logic signed [15:0] sample_q,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_i,
  output logic signed [15:0] out_q,
  output logic               frame_last
);

  logic [5:0] bin_low;
  logic [5:0] bin_high;
  logic signed [31:0] gain;
  logic busy;
  fbmf_pkg::cmd_t cmd;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_low <= 6'd0;
      bin_high <= 6'd63;
      gain <= 32'sd262144;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        fbmf_pkg::REG_BIN_LOW: bin_low <= pwdata[5:0];
        fbmf_pkg::REG_BIN_HIGH: bin_high <= pwdata[5:0];
        fbmf_pkg::REG_GAIN: gain <= signed'(pwdata);
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      fbmf_pkg::REG_BIN_LOW: prdata = {26'd0, bin_low};
      fbmf_pkg::REG_BIN_HIGH: prdata = {26'd0, bin_high};
      fbmf_pkg::REG_GAIN: prdata = gain;
      default: prdata = 32'd0;
    endcase
  end

  fbmf_ctrl #(
    .FRAME_LEN(FRAME_LEN)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .busy(busy),
    .cmd(cmd)
  );

  fbmf_datapath #(
    .FRAME_LEN(FRAME_LEN)
  ) u_datapath (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .sample_i(sample_i),
    .sample_q(sample_q),
    .bin_low(bin_low),
    .bin_high(bin_high),
    .gain(gain),
    .busy(busy),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_i(out_i),
    .out_q(out_q),
    .frame_last(frame_last)
  );

endmodule

FILE: tb/sv/fft_bin_mask_filter_checker.sv
`timescale 1ns / 1ps
// Checker for the FFT bin mask filter: watches the register port and both streams,
// predicts each filtered frame in fixed point and compares the outputs.
// Depends on fbmf_pkg for register indexes and the Q2.30 pi constant.
module fft_bin_mask_filter_checker #(
  parameter int FRAME_LEN = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [15:0] sample_i,
  input  logic signed [15:0] sample_q,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] out_i,
  input  logic signed [15:0] out_q,
  input  logic               frame_last,
  output int                 errors,
  output int                 pending
);

  typedef struct {
    logic signed [15:0] i;
    logic signed [15:0] q;
    logic               last;
  } filt_sample_t;

  filt_sample_t filtered_q[$];
  logic signed [15:0] frame_i[FRAME_LEN];
  logic signed [15:0] frame_q[FRAME_LEN];
  longint tw_cos[FRAME_LEN];
  longint tw_sin[FRAME_LEN];
  int fill;
  logic [5:0] band_lo;
  logic [5:0] band_hi;
  logic signed [31:0] out_gain;

  function automatic longint round_shift(longint v, int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  function automatic bit kept(int k);
    return k >= band_lo && k <= band_hi;
  endfunction

  initial begin
    longint unsigned x, x2, ts, tc, ds, dc, qd, rm;
    longint s, c;
    for (int m = 0; m < FRAME_LEN; m++) begin
      qd = 64'((4 * m) / FRAME_LEN);
      rm = 64'((4 * m) % FRAME_LEN);
      x = (fbmf_pkg::PI_Q30 * rm + 64'(FRAME_LEN)) / 64'(2 * FRAME_LEN);
      x2 = (x * x + 64'd536870912) >> 30;
      ts = x;
      tc = 64'd1073741824;
      s = x;
      c = 64'sd1073741824;
      for (int k = 1; k <= 9; k++) begin
        ds = 64'((2 * k) * (2 * k + 1));
        dc = 64'((2 * k - 1) * (2 * k));
        ts = (((ts * x2 + 64'd536870912) >> 30) + ds / 2) / ds;
        tc = (((tc * x2 + 64'd536870912) >> 30) + dc / 2) / dc;
        if (k % 2 == 1) begin
          s = s - longint'(ts);
          c = c - longint'(tc);
        end else begin
          s = s + longint'(ts);
          c = c + longint'(tc);
        end
      end
      case (qd % 4)
        0: begin tw_cos[m] = c;  tw_sin[m] = s;  end
        1: begin tw_cos[m] = -s; tw_sin[m] = c;  end
        2: begin tw_cos[m] = -c; tw_sin[m] = -s; end
        default: begin tw_cos[m] = s; tw_sin[m] = -c; end
      endcase
    end
  end

  task automatic filter_frame();
    longint spec_re[FRAME_LEN];
    longint spec_im[FRAME_LEN];
    longint ar, ai, yr, yi, g;
    int m;
    filt_sample_t r;
    g = longint'(out_gain);
    for (int k = 0; k < FRAME_LEN; k++) begin
      ar = 0;
      ai = 0;
      if (kept(k)) begin
        for (int n = 0; n < FRAME_LEN; n++) begin
          m = (k * n) % FRAME_LEN;
          ar += longint'(frame_i[n]) * tw_cos[m] + longint'(frame_q[n]) * tw_sin[m];
          ai += longint'(frame_q[n]) * tw_cos[m] - longint'(frame_i[n]) * tw_sin[m];
        end
        ar = round_shift(ar, 22);
        ai = round_shift(ai, 22);
      end
      spec_re[k] = longint'(int'(ar));
      spec_im[k] = longint'(int'(ai));
    end
    for (int n = 0; n < FRAME_LEN; n++) begin
      yr = 0;
      yi = 0;
      for (int k = 0; k < FRAME_LEN; k++) begin
        if (kept(k)) begin
          m = (k * n) % FRAME_LEN;
          yr += round_shift(spec_re[k] * tw_cos[m] - spec_im[k] * tw_sin[m], 8);
          yi += round_shift(spec_re[k] * tw_sin[m] + spec_im[k] * tw_cos[m], 8);
        end
      end
      yr = round_shift(yr, 27);
      yi = round_shift(yi, 27);
      r.i = clamp16(round_shift(yr * g, 27));
      r.q = clamp16(round_shift(yi * g, 27));
      r.last = (n == FRAME_LEN - 1);
      filtered_q.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    filt_sample_t e;
    if (rst) begin
      fill = 0;
      band_lo = 6'd0;
      band_hi = 6'd63;
      out_gain = 32'sd262144;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          fbmf_pkg::REG_BIN_LOW:  band_lo = pwdata[5:0];
          fbmf_pkg::REG_BIN_HIGH: band_hi = pwdata[5:0];
          fbmf_pkg::REG_GAIN:     out_gain = pwdata;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (filtered_q.size() == 0) begin
          $error("unexpected output transaction: out_i %0d out_q %0d", out_i, out_q);
          errors++;
        end else begin
          e = filtered_q.pop_front();
          if (out_i !== e.i) begin
            $error("out_i: expected %0d, actual %0d", e.i, out_i);
            errors++;
          end
          if (out_q !== e.q) begin
            $error("out_q: expected %0d, actual %0d", e.q, out_q);
            errors++;
          end
          if (frame_last !== e.last) begin
            $error("frame_last: expected %0d, actual %0d", e.last, frame_last);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        frame_i[fill] = sample_i;
        frame_q[fill] = sample_q;
        if (fill == FRAME_LEN - 1) begin
          fill = 0;
          filter_frame();
        end else begin
          fill++;
        end
      end
    end
    pending = filtered_q.size();
  end

endmodule

FILE: tb/sv/fft_bin_mask_filter_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for the FFT bin mask filter: drives registers and sample frames
// with random gaps and output stalls, and reports the verdict.
// Depends on fbmf_pkg, fft_bin_mask_filter_top and fft_bin_mask_filter_checker.
module fft_bin_mask_filter_top_tb;

  localparam int FRAME_LEN = 64;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] sample_i = '0;
  logic signed [15:0] sample_q = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_i;
  logic signed [15:0] out_q;
  logic frame_last;
  int errors;
  int pending;
  bit no_gaps;
  int stall_left = 0;
  int free_run = 0;

  always #1 clk = ~clk;

  fft_bin_mask_filter_top #(.FRAME_LEN(FRAME_LEN)) dut (.*);

  fft_bin_mask_filter_checker #(.FRAME_LEN(FRAME_LEN)) chk (.*);

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [15:0] corner_value(int j);
    case (j % 5)
      0: return 16'sd32767;
      1: return -16'sd32768;
      2: return 16'sd0;
      3: return -16'sd1;
      default: return 16'sd1;
    endcase
  endfunction

  always @(posedge clk) begin
    if (free_run > 0) begin
      free_run <= free_run - 1;
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 199) == 0) free_run <= 300;
      else stall_left <= gap_len();
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(logic [5:0] lo, logic [5:0] hi, logic [31:0] g);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    reg_write(fbmf_pkg::REG_BIN_LOW, {26'd0, lo});
    reg_write(fbmf_pkg::REG_BIN_HIGH, {26'd0, hi});
    reg_write(fbmf_pkg::REG_GAIN, g);
  endtask

  // Sends one frame; the first n_corner samples walk through the corner values.
  task automatic send_frame(int n_corner, bit small_amp);
    int gap;
    logic [15:0] ri;
    logic [15:0] rq;
    no_gaps = ($urandom_range(0, 3) == 0);
    for (int j = 0; j < FRAME_LEN; j++) begin
      gap = no_gaps ? 0 : gap_len();
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      ri = 16'($urandom);
      rq = 16'($urandom);
      if (j < n_corner) begin
        ri = corner_value(j);
        rq = corner_value(j / 5);
      end else if (small_amp) begin
        ri = 16'($urandom_range(0, 2000) - 1000);
        rq = 16'($urandom_range(0, 2000) - 1000);
      end
      in_valid <= 1'b1;
      sample_i <= ri;
      sample_q <= rq;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_frame(25, 1'b0);
    configure(6'd0, 6'd63, 32'h7fffffff);
    send_frame(0, 1'b0);
    configure(6'd5, 6'd20, 32'h80000000);
    send_frame(0, 1'b0);
    configure(6'd40, 6'd10, $urandom);
    send_frame(0, 1'b0);
    configure(6'd63, 6'd63, 32'd262144);
    send_frame(0, 1'b1);
    configure(6'd0, 6'd0, 32'd16777216);
    send_frame(0, 1'b0);
    configure(6'($urandom_range(0, 31)), 6'($urandom_range(20, 63)),
              $urandom_range(0, 4194304));
    send_frame(0, 1'b1);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule

FILE: sim.f
hdl/fbmf_pkg.sv
hdl/fbmf_ctrl.sv
hdl/fbmf_datapath.sv
hdl/fft_bin_mask_filter_top.sv
tb/sv/fft_bin_mask_filter_checker.sv
tb/sv/fft_bin_mask_filter_top_tb.sv
